[design/triac_phase_angle_controller_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the triac phase-angle controller
// Shared property wrappers, clocked on i_clk, off while in reset.
// ---------------------------------------------------------------------------
`ifndef TRIAC_PHASE_ANGLE_CONTROLLER_DEFINES_SVH
`define TRIAC_PHASE_ANGLE_CONTROLLER_DEFINES_SVH

// consequent must hold in the same cycle
`define TPAC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the next cycle
`define TPAC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/tpac_pkg.sv]
// ---------------------------------------------------------------------------
// tpac_pkg
// Types, constants and helpers shared by the phase-angle controller.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tpac_pkg;

    localparam int LEVEL_W     = 13;
    localparam int CFG_W       = 16;
    localparam int OUT_W       = 16;
    localparam int PROD_W      = CFG_W + LEVEL_W;
    localparam int LEVEL_SHIFT = 12;

    localparam logic [LEVEL_W-1:0] LEVEL_FULL     = 13'd4096;
    localparam logic [LEVEL_W-1:0] LEVEL_LOW_CUT  = 13'd128;
    localparam logic [LEVEL_W-1:0] LEVEL_HIGH_CUT = 13'd3967;

    localparam logic [CFG_W-1:0] HALF_CYCLE_RST = 16'd200;
    localparam logic [CFG_W-1:0] GATE_PULSE_RST = 16'd2;

    // register indexes (word address paddr[3:2])
    localparam logic [1:0] REG_HALF_CYCLE = 2'd0;
    localparam logic [1:0] REG_GATE_PULSE = 2'd1;
    localparam logic [1:0] REG_SIMULATE   = 2'd2;

    typedef enum logic [1:0] {
        OP_TICK       = 2'd0,
        OP_ZERO_CROSS = 2'd1,
        OP_SET_LEVEL  = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_POST
    } t_state;

    typedef struct packed {
        logic             simulate;
        logic [CFG_W-1:0] half_cycle;
        logic [CFG_W-1:0] gate_pulse;
    } t_eval_cfg;

    function automatic logic [LEVEL_W-1:0] clamp_level(input logic [LEVEL_W-1:0] lvl);
        logic [LEVEL_W-1:0] res;
        res = lvl;
        if (lvl < LEVEL_LOW_CUT) begin
            res = '0;
        end
        if (lvl > LEVEL_HIGH_CUT) begin
            res = LEVEL_FULL;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[design/tpac_level_store.sv]
// ---------------------------------------------------------------------------
// tpac_level_store
// Per-channel level memory, one write and one registered read per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpac_level_store #(
    parameter int CHANNELS = 16,
    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_wr_en,
    input  wire logic [AW-1:0]                i_wr_addr,
    input  wire logic [tpac_pkg::LEVEL_W-1:0] i_wr_level,
    input  wire logic                         i_rd_en,
    input  wire logic [AW-1:0]                i_rd_addr,
    output logic                              o_rd_vld,
    output logic [AW-1:0]                     o_rd_addr,
    output logic [tpac_pkg::LEVEL_W-1:0]      o_level
);

    logic [tpac_pkg::LEVEL_W-1:0] r_mem [CHANNELS];
    logic [tpac_pkg::LEVEL_W-1:0] r_q;
    logic [CHANNELS-1:0]          r_written;
    logic                         r_q_ok;
    logic                         r_rd_vld;
    logic [AW-1:0]                r_rd_addr;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_level;
        end
        if (i_rd_en) begin
            r_q       <= r_mem[i_rd_addr];
            r_q_ok    <= r_written[i_rd_addr];
            r_rd_addr <= i_rd_addr;
        end
    end

    // written flags stand in for the all-zero reset of the array
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            r_rd_vld <= i_rd_en;
            if (i_wr_en) begin
                r_written[i_wr_addr] <= 1'b1;
            end
        end
    end

    assign o_rd_vld  = r_rd_vld;
    assign o_rd_addr = r_rd_addr;
    assign o_level   = r_q_ok ? r_q : '0;

endmodule

`default_nettype wire

[design/tpac_chan_eval.sv]
// ---------------------------------------------------------------------------
// tpac_chan_eval
// Two-stage channel evaluator: firing delay, then pin compare.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpac_chan_eval #(
    parameter int CHANNELS   = 16,
    parameter int COUNT_BITS = 16,
    localparam int AW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
    localparam int CMPW = ((COUNT_BITS > tpac_pkg::CFG_W + 1) ? COUNT_BITS
                                                              : tpac_pkg::CFG_W + 1) + 1
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_vld,
    input  wire logic [AW-1:0]                i_idx,
    input  wire logic [tpac_pkg::LEVEL_W-1:0] i_level,
    input  wire tpac_pkg::t_eval_cfg          i_cfg,
    input  wire logic [COUNT_BITS-1:0]        i_count,
    output logic                              o_vld,
    output logic [AW-1:0]                     o_idx,
    output logic                              o_pin
);

    logic [tpac_pkg::PROD_W-1:0] prod;
    logic [tpac_pkg::CFG_W-1:0]  r_delay;
    logic                        r_s1_vld;
    logic [AW-1:0]               r_s1_idx;
    logic [CMPW-1:0]             cnt_x;
    logic [CMPW-1:0]             dly_x;
    logic [CMPW-1:0]             end_x;
    logic                        pin;
    logic                        r_pin;
    logic                        r_s2_vld;
    logic [AW-1:0]               r_s2_idx;

    // delay = period * (4096 - level) >> 12, never above period
    assign prod = tpac_pkg::PROD_W'(i_cfg.half_cycle)
                * tpac_pkg::PROD_W'(tpac_pkg::LEVEL_FULL - i_level);

    always_ff @(posedge i_clk) begin
        r_delay  <= prod[tpac_pkg::LEVEL_SHIFT +: tpac_pkg::CFG_W];
        r_s1_idx <= i_idx;
        r_pin    <= pin;
        r_s2_idx <= r_s1_idx;
    end

    assign cnt_x = CMPW'(i_count);
    assign dly_x = CMPW'(r_delay);
    assign end_x = dly_x + CMPW'(i_cfg.gate_pulse);

    always_comb begin
        if (i_cfg.simulate) begin
            pin = (cnt_x >= dly_x);
        end else begin
            pin = (cnt_x < dly_x) || (cnt_x > end_x);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_vld;
            r_s2_vld <= r_s1_vld;
        end
    end

    assign o_vld = r_s2_vld;
    assign o_idx = r_s2_idx;
    assign o_pin = r_pin;

endmodule

`default_nettype wire

[design/triac_phase_angle_controller.sv]
// ---------------------------------------------------------------------------
// triac_phase_angle_controller
// Multi-channel leading-edge phase-angle dimmer for mains loads.
// ---------------------------------------------------------------------------
// Every transaction on the input channel returns exactly one gate_pattern
// transaction. A set-level transaction writes one channel's level (clamped:
// below 128 reads as off, above 3967 as fully on) and a zero-cross
// transaction clears the tick counter (ignored in simulate mode); both
// repeat the last pattern. A tick transaction advances the counter and then
// walks the level memory one channel per cycle through a two-stage
// evaluator (delay multiply, then compare); the single read port of the
// level memory sets that pace. The result register frees the input side: a
// new transaction is taken while the previous pattern still waits on
// o_valid. Configuration (APB, regs at 0x0 period, 0x4 gate width, 0x8
// simulate) is expected only while the block is idle. Channels above 16 are
// evaluated but not visible in the 16-bit pattern.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "triac_phase_angle_controller_defines.svh"

module triac_phase_angle_controller #(
    parameter int CHANNELS   = 16,
    parameter int COUNT_BITS = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // configuration
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [3:0]                   paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    // command channel
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [1:0]                   i_operation,
    input  wire logic [3:0]                   i_channel,
    input  wire logic [tpac_pkg::LEVEL_W-1:0] i_level,
    // pattern channel
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [tpac_pkg::OUT_W-1:0]        o_gate_pattern
);

    localparam int AW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNTW = $clog2(CHANNELS + 1);
    localparam int CMPW = ((COUNT_BITS > tpac_pkg::CFG_W + 1) ? COUNT_BITS
                                                              : tpac_pkg::CFG_W + 1) + 1;
    localparam logic [CNTW-1:0] LP_CH   = CNTW'(CHANNELS);
    localparam logic [AW-1:0]   LP_LAST = AW'(CHANNELS - 1);
    localparam logic [6:0]      LP_CH7  = 7'(CHANNELS);

    // configuration registers
    logic [tpac_pkg::CFG_W-1:0] r_hct;
    logic [tpac_pkg::CFG_W-1:0] r_gate;
    logic                       r_sim;
    logic                       cfg_wr;
    tpac_pkg::t_eval_cfg        eval_cfg;

    // control
    tpac_pkg::t_state           r_state, n_state;
    logic [COUNT_BITS-1:0]      r_cnt, n_cnt;
    logic [CNTW-1:0]            r_rd_cnt, n_rd_cnt;
    logic [CHANNELS-1:0]        r_pins, n_pins;
    logic [CHANNELS-1:0]        r_acc, n_acc;
    logic                       r_out_vld, n_out_vld;
    logic [tpac_pkg::OUT_W-1:0] r_out, n_out;

    logic                       accept;
    tpac_pkg::t_op              op;
    logic [COUNT_BITS-1:0]      cnt_inc;
    logic                       wrap;
    logic [6:0]                 ch7;
    logic                       ch_ok;
    logic                       wr_en;
    logic                       rd_en;

    // store / evaluator links
    logic                         st_vld;
    logic [AW-1:0]                st_idx;
    logic [tpac_pkg::LEVEL_W-1:0] st_level;
    logic                         pin_vld;
    logic [AW-1:0]                pin_idx;
    logic                         pin;

    // ---------------- APB ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hct  <= tpac_pkg::HALF_CYCLE_RST;
            r_gate <= tpac_pkg::GATE_PULSE_RST;
            r_sim  <= 1'b0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                tpac_pkg::REG_HALF_CYCLE: r_hct  <= pwdata[tpac_pkg::CFG_W-1:0];
                tpac_pkg::REG_GATE_PULSE: r_gate <= pwdata[tpac_pkg::CFG_W-1:0];
                tpac_pkg::REG_SIMULATE:   r_sim  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            tpac_pkg::REG_HALF_CYCLE: prdata = 32'(r_hct);
            tpac_pkg::REG_GATE_PULSE: prdata = 32'(r_gate);
            tpac_pkg::REG_SIMULATE:   prdata = 32'(r_sim);
            default:                  prdata = '0;
        endcase
    end

    assign eval_cfg = '{simulate: r_sim, half_cycle: r_hct, gate_pulse: r_gate};

    // ---------------- command decode ----------------
    assign o_ready = (r_state == tpac_pkg::ST_IDLE);
    assign accept  = i_valid && o_ready;
    assign op      = tpac_pkg::t_op'(i_operation);

    // saturating advance; in simulate mode wrap at the nominal period
    assign cnt_inc = (r_cnt == '1) ? r_cnt : r_cnt + 1'b1;
    assign wrap    = r_sim && (CMPW'(cnt_inc) == CMPW'(r_hct));

    assign ch7   = {3'b000, i_channel};
    assign ch_ok = (ch7 < LP_CH7);

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tpac_pkg::ST_IDLE;
            r_cnt     <= '0;
            r_rd_cnt  <= '0;
            r_pins    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_rd_cnt  <= n_rd_cnt;
            r_pins    <= n_pins;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_out <= n_out;
    end

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_rd_cnt  = r_rd_cnt;
        n_pins    = r_pins;
        n_acc     = r_acc;
        n_out     = r_out;
        n_out_vld = r_out_vld && !i_ready;
        wr_en     = 1'b0;
        rd_en     = 1'b0;

        case (r_state)
            tpac_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = tpac_pkg::ST_POST;
                    case (op)
                        tpac_pkg::OP_TICK: begin
                            n_cnt    = wrap ? '0 : cnt_inc;
                            n_rd_cnt = '0;
                            n_state  = tpac_pkg::ST_RUN;
                        end
                        tpac_pkg::OP_ZERO_CROSS: begin
                            if (!r_sim) begin
                                n_cnt = '0;
                            end
                        end
                        tpac_pkg::OP_SET_LEVEL: begin
                            wr_en = ch_ok;
                        end
                        default: ;
                    endcase
                end
            end
            tpac_pkg::ST_RUN: begin
                // one level read per cycle; results pass the read and eval registers
                if (r_rd_cnt < LP_CH) begin
                    rd_en    = 1'b1;
                    n_rd_cnt = r_rd_cnt + 1'b1;
                end
                if (pin_vld) begin
                    n_acc[pin_idx] = pin;
                    if (pin_idx == LP_LAST) begin
                        n_pins  = n_acc;
                        n_state = tpac_pkg::ST_POST;
                    end
                end
            end
            tpac_pkg::ST_POST: begin
                if (!r_out_vld || i_ready) begin
                    n_out_vld = 1'b1;
                    n_out     = tpac_pkg::OUT_W'(r_pins);
                    n_state   = tpac_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tpac_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_valid        = r_out_vld;
    assign o_gate_pattern = r_out;

    // ---------------- datapath ----------------
    tpac_level_store #(
        .CHANNELS (CHANNELS)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (wr_en),
        .i_wr_addr  (ch7[AW-1:0]),
        .i_wr_level (tpac_pkg::clamp_level(i_level)),
        .i_rd_en    (rd_en),
        .i_rd_addr  (r_rd_cnt[AW-1:0]),
        .o_rd_vld   (st_vld),
        .o_rd_addr  (st_idx),
        .o_level    (st_level)
    );

    tpac_chan_eval #(
        .CHANNELS   (CHANNELS),
        .COUNT_BITS (COUNT_BITS)
    ) u_eval (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (st_vld),
        .i_idx   (st_idx),
        .i_level (st_level),
        .i_cfg   (eval_cfg),
        .i_count (r_cnt),
        .o_vld   (pin_vld),
        .o_idx   (pin_idx),
        .o_pin   (pin)
    );

    // ---------------- assertions ----------------
    `TPAC_ASSERT_SAME(a_no_write_busy, r_state != tpac_pkg::ST_IDLE, !wr_en, "level write while busy")
    `TPAC_ASSERT_SAME(a_idle_pipe_empty, r_state == tpac_pkg::ST_IDLE, !pin_vld && !st_vld, "evaluator busy in idle")
    `TPAC_ASSERT_NEXT(a_last_to_post, r_state == tpac_pkg::ST_RUN && pin_vld && pin_idx == LP_LAST, r_state == tpac_pkg::ST_POST, "tick did not complete")
    `TPAC_ASSERT_SAME(a_sim_wrap, r_state == tpac_pkg::ST_RUN && r_sim, CMPW'(r_cnt) != CMPW'(r_hct), "counter missed wrap")

endmodule

`default_nettype wire
